### rtl/xfc_pkg.sv
// Package for the XOR frame checker: frame constants, status codes, the job record
// passed from the front end to the reply generator, and the reply byte table.
// No dependencies.
`timescale 1ns / 1ps

package xfc_pkg;

  // Frame limits
  localparam int MAX_FRAME   = 64;
  localparam int MIN_LEN     = 10;
  localparam int CNT_W       = $clog2(MAX_FRAME + 1);
  localparam int LEN_W       = 7;
  localparam int REPLY_LEN   = 12;
  localparam int IDX_W       = $clog2(REPLY_LEN);

  // Frame bytes
  localparam logic [7:0] HDR_0    = 8'h59;
  localparam logic [7:0] HDR_1    = 8'h58;
  localparam logic [7:0] TAIL_0   = 8'h0D;
  localparam logic [7:0] TAIL_1   = 8'h0A;
  localparam logic [7:0] NAK_ID   = 8'hBB;
  localparam logic [7:0] NAK_FUNC = 8'h02;
  localparam logic [7:0] ZERO_B   = 8'h00;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_RECV = 2'd1;
  localparam logic [1:0] ST_FMT  = 2'd2;
  localparam logic [1:0] ST_SUM  = 2'd3;

  // Input modes
  localparam logic MODE_DATA    = 1'b0;
  localparam logic MODE_TIMEOUT = 1'b1;

  // One finished frame, waiting for its verdict or reply
  typedef struct packed {
    logic [1:0]       code;
    logic [7:0]       command;
    logic [LEN_W-1:0] length;
  } job_t;

  // Byte of the negative reply at a given position
  function automatic logic [7:0] reply_byte(input logic [IDX_W-1:0] idx,
                                            input logic [7:0]       cmd,
                                            input logic [1:0]       code);
    logic [7:0] x;
    logic [7:0] b;
    x = HDR_0 ^ HDR_1 ^ ZERO_B ^ NAK_ID ^ ZERO_B ^ ZERO_B ^ NAK_FUNC ^ cmd
        ^ {6'd0, code};
    case (idx)
      4'd0:    b = HDR_0;
      4'd1:    b = HDR_1;
      4'd2:    b = ZERO_B;
      4'd3:    b = NAK_ID;
      4'd4:    b = ZERO_B;
      4'd5:    b = ZERO_B;
      4'd6:    b = NAK_FUNC;
      4'd7:    b = cmd;
      4'd8:    b = {6'd0, code};
      4'd9:    b = x;
      4'd10:   b = TAIL_0;
      4'd11:   b = TAIL_1;
      default: b = ZERO_B;
    endcase
    return b;
  endfunction

endpackage

### rtl/xfc_front.sv
// Front end of the frame checker: takes bytes and timeouts, tracks the frame,
// classifies it on the last byte or a timeout and pushes a job. Depends on xfc_pkg.
`timescale 1ns / 1ps

module xfc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                mode_i,
  input  logic [7:0]          byte_value_i,
  input  logic                last_i,
  input  logic                q_full_i,
  output logic                push_o,
  output xfc_pkg::job_t       job_o
);

  logic [xfc_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0] first_q, first_d, second_q, second_d, cmd_q, cmd_d;
  logic [7:0] older_q, older_d, newer_q, newer_d, xor_q, xor_d;
  logic       accept, store, finish;
  logic [1:0] code;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign store      = (mode_i == xfc_pkg::MODE_DATA) &&
                      (cnt_q < xfc_pkg::CNT_W'(xfc_pkg::MAX_FRAME));
  assign finish     = (mode_i == xfc_pkg::MODE_TIMEOUT) || last_i;

  // Frame state after this byte
  always_comb begin
    cnt_d    = cnt_q;
    first_d  = first_q;
    second_d = second_q;
    cmd_d    = cmd_q;
    older_d  = older_q;
    newer_d  = newer_q;
    xor_d    = xor_q;
    if (store) begin
      if (cnt_q == xfc_pkg::CNT_W'(0)) first_d = byte_value_i;
      if (cnt_q == xfc_pkg::CNT_W'(1)) second_d = byte_value_i;
      if (cnt_q == xfc_pkg::CNT_W'(3)) cmd_d = byte_value_i;
      xor_d   = xor_q ^ byte_value_i;
      older_d = newer_q;
      newer_d = byte_value_i;
      cnt_d   = cnt_q + xfc_pkg::CNT_W'(1);
    end
  end

  // Checks in priority order
  always_comb begin
    if (mode_i == xfc_pkg::MODE_TIMEOUT) begin
      code = xfc_pkg::ST_RECV;
    end else if (cnt_d < xfc_pkg::CNT_W'(xfc_pkg::MIN_LEN)) begin
      code = xfc_pkg::ST_RECV;
    end else if (first_d != xfc_pkg::HDR_0 || second_d != xfc_pkg::HDR_1) begin
      code = xfc_pkg::ST_FMT;
    end else if (older_d != xfc_pkg::TAIL_0 || newer_d != xfc_pkg::TAIL_1) begin
      code = xfc_pkg::ST_FMT;
    end else if ((xor_d ^ older_d ^ newer_d) != 8'd0) begin
      code = xfc_pkg::ST_SUM;
    end else begin
      code = xfc_pkg::ST_OK;
    end
  end

  assign push_o         = accept && finish;
  assign job_o.code     = code;
  assign job_o.command  = cmd_d;
  assign job_o.length   = xfc_pkg::LEN_W'(cnt_d);

  // Frame state; cleared once a frame ends
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      first_q  <= '0;
      second_q <= '0;
      cmd_q    <= '0;
      older_q  <= '0;
      newer_q  <= '0;
      xor_q    <= '0;
    end else if (accept) begin
      if (finish) begin
        cnt_q    <= '0;
        first_q  <= '0;
        second_q <= '0;
        cmd_q    <= '0;
        older_q  <= '0;
        newer_q  <= '0;
        xor_q    <= '0;
      end else begin
        cnt_q    <= cnt_d;
        first_q  <= first_d;
        second_q <= second_d;
        cmd_q    <= cmd_d;
        older_q  <= older_d;
        newer_q  <= newer_d;
        xor_q    <= xor_d;
      end
    end
  end

endmodule

### rtl/xfc_queue.sv
// Two-entry job queue between the front end and the reply generator.
// Depends on xfc_pkg.
`timescale 1ns / 1ps

module xfc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  xfc_pkg::job_t push_job_i,
  input  logic          pop_i,
  output logic          valid_o,
  output logic          full_o,
  output xfc_pkg::job_t head_o
);

  xfc_pkg::job_t mem_q [2];
  logic          wptr_q, rptr_q;
  logic [1:0]    cnt_q;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign head_o  = mem_q[rptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_job_i;
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= !wptr_q;
      if (pop_i) rptr_q <= !rptr_q;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

### rtl/xfc_back.sv
// Back end of the frame checker: turns each job into one verdict or a 12-byte
// negative reply, one result per cycle while out_ready_i is high. Depends on xfc_pkg.
`timescale 1ns / 1ps

module xfc_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  xfc_pkg::job_t              q_job_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 status_o,
  output logic [7:0]                 command_o,
  output logic [xfc_pkg::LEN_W-1:0]  frame_length_o,
  output logic                       reply_valid_o,
  output logic [7:0]                 reply_byte_o,
  output logic                       end_of_run_o
);

  logic                      busy_q;
  xfc_pkg::job_t             job_q;
  logic [xfc_pkg::IDX_W-1:0] idx_q;
  logic                      is_nak, last_res, done;

  assign is_nak   = (job_q.code != xfc_pkg::ST_OK);
  assign last_res = !is_nak || (idx_q == xfc_pkg::IDX_W'(xfc_pkg::REPLY_LEN - 1));
  assign done     = busy_q && out_ready_i && last_res;
  assign pop_o    = q_valid_i && (!busy_q || done);

  // Result fields
  assign out_valid_o    = busy_q;
  assign status_o       = job_q.code;
  assign command_o      = job_q.command;
  assign frame_length_o = job_q.length;
  assign reply_valid_o  = is_nak;
  assign reply_byte_o   = is_nak ? xfc_pkg::reply_byte(idx_q, job_q.command, job_q.code)
                                 : 8'd0;
  assign end_of_run_o   = last_res;

  // Job payload
  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= q_job_i;
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (done) begin
      busy_q <= 1'b0;
    end else if (busy_q && out_ready_i) begin
      idx_q <= idx_q + xfc_pkg::IDX_W'(1);
    end
  end

endmodule

### rtl/xor_frame_checker_with_nak_unit.sv
// Top level of the XOR frame checker with negative reply.
// Depends on xfc_pkg, xfc_front, xfc_queue and xfc_back.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid_i / in_ready_o): one request per received byte
//   (mode_i = 0, byte_value_i, last_i on the final byte) or a receive timeout
//   (mode_i = 1). A byte is taken every cycle while the job queue has room.
//   Output channel (out_valid_o / out_ready_i): a good frame gives one verdict
//   with status 0; a bad frame or a timeout gives 12 results carrying the
//   reply frame, end_of_run_o marks the final one.
//   Path: the final byte or timeout is registered as a job in the job queue,
//   then loaded into the sequencer once it is free, which offers the first result.
//   Throughput: one input byte per cycle while the job queue has room; the
//   output side delivers one result per cycle while out_ready_i is high.
//   The two-entry job queue between the classifier and the reply sequencer
//   sets how many finished frames may wait.
//   Receiver stall: results hold; bytes of the next frame keep flowing in
//   until two finished frames are queued, then in_ready_o drops.
//   Reset: frame state, queue and sequencer clear at once; no clearing pass.
module xor_frame_checker_with_nak_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      mode_i,
  input  logic [7:0]                byte_value_i,
  input  logic                      last_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                status_o,
  output logic [7:0]                command_o,
  output logic [xfc_pkg::LEN_W-1:0] frame_length_o,
  output logic                      reply_valid_o,
  output logic [7:0]                reply_byte_o,
  output logic                      end_of_run_o
);

  logic          push, pop, q_valid, q_full;
  xfc_pkg::job_t push_job, head_job;

  // Classifier
  xfc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .byte_value_i (byte_value_i),
    .last_i       (last_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .job_o        (push_job)
  );

  // Job queue
  xfc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .full_o     (q_full),
    .head_o     (head_job)
  );

  // Reply sequencer
  xfc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_job_i        (head_job),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .command_o      (command_o),
    .frame_length_o (frame_length_o),
    .reply_valid_o  (reply_valid_o),
    .reply_byte_o   (reply_byte_o),
    .end_of_run_o   (end_of_run_o)
  );

endmodule

### verif/tb_top.sv
// Self-checking testbench for xor_frame_checker_with_nak_unit: directed table, then random frames.
// Holds its own frame tracker and checks every result. Depends on xfc_pkg and the unit RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int RANDOM_ITEMS = 380;
  localparam int HOLD_AFTER   = 150;   // requests accepted before the long output hold
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 2000;  // cycles with no handshake on either side
  localparam int DRAIN_CYCLES = 20;

  // One input request, optionally with its outcome fixed by hand
  typedef struct {
    logic                      mode;
    logic [7:0]                value;
    logic                      last;
    bit                        fixed;
    logic [1:0]                st;
    logic [7:0]                cmd;
    logic [xfc_pkg::LEN_W-1:0] len;
  } request_t;

  // One output result, in port order
  typedef struct packed {
    logic [1:0]                status;
    logic [7:0]                command;
    logic [xfc_pkg::LEN_W-1:0] frame_length;
    logic                      reply_valid;
    logic [7:0]                reply_data;
    logic                      end_of_run;
  } answer_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic                      mode_i;
  logic [7:0]                byte_value_i;
  logic                      last_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [1:0]                status_o;
  logic [7:0]                command_o;
  logic [xfc_pkg::LEN_W-1:0] frame_length_o;
  logic                      reply_valid_o;
  logic [7:0]                reply_byte_o;
  logic                      end_of_run_o;

  // Frame tracker state
  logic [xfc_pkg::LEN_W-1:0] rx_count = '0;
  logic [7:0]                rx_hdr0  = '0;
  logic [7:0]                rx_hdr1  = '0;
  logic [7:0]                rx_cmd   = '0;
  logic [7:0]                rx_tail0 = '0;
  logic [7:0]                rx_tail1 = '0;
  logic [7:0]                rx_xor   = '0;

  answer_t answers_due[$];
  int      errors         = 0;
  int      items_used     = 0;
  int      items_accepted = 0;
  int      burst_left     = 0;
  int      idle_cycles    = 0;

  xor_frame_checker_with_nak_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .byte_value_i   (byte_value_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .command_o      (command_o),
    .frame_length_o (frame_length_o),
    .reply_valid_o  (reply_valid_o),
    .reply_byte_o   (reply_byte_o),
    .end_of_run_o   (end_of_run_o)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic request_t mk_req(logic m, logic [7:0] v, logic l, bit fixed = 1'b0,
                                      logic [1:0] st = xfc_pkg::ST_OK,
                                      logic [7:0] cmd = 8'h00,
                                      logic [xfc_pkg::LEN_W-1:0] len = '0);
    request_t r;
    r.mode  = m;
    r.value = v;
    r.last  = l;
    r.fixed = fixed;
    r.st    = st;
    r.cmd   = cmd;
    r.len   = len;
    return r;
  endfunction

  // Feed one accepted request to the tracker; returns 1 when it closes a frame or times out
  function automatic bit advance_frame(input request_t r, output logic [1:0] st,
                                       output logic [7:0] cmd,
                                       output logic [xfc_pkg::LEN_W-1:0] len);
    bit done;
    done = 1'b0;
    st   = xfc_pkg::ST_OK;
    if (r.mode == xfc_pkg::MODE_TIMEOUT) begin
      st   = xfc_pkg::ST_RECV;
      done = 1'b1;
      items_used++;
    end else begin
      if (rx_count < xfc_pkg::MAX_FRAME || r.last) items_used++;
      // store the byte unless the frame is already full
      if (rx_count < xfc_pkg::MAX_FRAME) begin
        case (rx_count)
          0:       rx_hdr0 = r.value;
          1:       rx_hdr1 = r.value;
          3:       rx_cmd  = r.value;
          default: ;
        endcase
        rx_xor   = rx_xor ^ r.value;
        rx_tail0 = rx_tail1;
        rx_tail1 = r.value;
        rx_count = rx_count + 1'b1;
      end
      // checks in priority order: length, header, tail, checksum
      if (r.last) begin
        done = 1'b1;
        if (rx_count < xfc_pkg::MIN_LEN) st = xfc_pkg::ST_RECV;
        else if (rx_hdr0 != xfc_pkg::HDR_0 || rx_hdr1 != xfc_pkg::HDR_1) st = xfc_pkg::ST_FMT;
        else if (rx_tail0 != xfc_pkg::TAIL_0 || rx_tail1 != xfc_pkg::TAIL_1)
          st = xfc_pkg::ST_FMT;
        else if ((rx_xor ^ rx_tail0 ^ rx_tail1) != 8'h00) st = xfc_pkg::ST_SUM;
      end
    end
    cmd = rx_cmd;
    len = rx_count;
    if (done) begin
      rx_count = '0;
      rx_hdr0  = '0;
      rx_hdr1  = '0;
      rx_cmd   = '0;
      rx_tail0 = '0;
      rx_tail1 = '0;
      rx_xor   = '0;
    end
    return done;
  endfunction

  // Queue a good-frame verdict, or the twelve bytes of the negative reply
  function automatic void push_answer(logic [1:0] st, logic [7:0] cmd,
                                      logic [xfc_pkg::LEN_W-1:0] len);
    logic [xfc_pkg::REPLY_LEN-1:0][7:0] nak;
    logic [7:0]                         sum;
    if (st == xfc_pkg::ST_OK) begin
      answers_due.push_back({xfc_pkg::ST_OK, cmd, len, 1'b0, 8'h00, 1'b1});
      return;
    end
    nak = {xfc_pkg::TAIL_1, xfc_pkg::TAIL_0, 8'h00, {6'd0, st}, cmd, xfc_pkg::NAK_FUNC,
           xfc_pkg::ZERO_B, xfc_pkg::ZERO_B, xfc_pkg::NAK_ID, xfc_pkg::ZERO_B,
           xfc_pkg::HDR_1, xfc_pkg::HDR_0};
    sum = 8'h00;
    for (int i = 0; i < 9; i++) sum = sum ^ nak[i];
    nak[9] = sum;
    for (int i = 0; i < xfc_pkg::REPLY_LEN; i++)
      answers_due.push_back({st, cmd, len, 1'b1, nak[i], i == xfc_pkg::REPLY_LEN - 1});
  endfunction

  function automatic string show(answer_t a);
    return $sformatf("st=%0d cmd=%h len=%0d rv=%b byte=%h eor=%b", a.status, a.command,
                     a.frame_length, a.reply_valid, a.reply_data, a.end_of_run);
  endfunction

  task automatic flag_error(input string what);
    errors++;
    if (errors <= 10) $display("[%0t] %s", $time, what);
  endtask

  // Drive one request in bursts with random gaps; returns at the falling edge after acceptance
  task automatic send_item(input request_t r);
    int                        gap;
    logic [1:0]                st;
    logic [7:0]                cmd;
    logic [xfc_pkg::LEN_W-1:0] len;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(1, 24);
      gap        = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid_i   <= 1'b1;
    mode_i       <= r.mode;
    byte_value_i <= r.value;
    last_i       <= r.last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_accepted++;
    burst_left--;
    if (advance_frame(r, st, cmd, len)) begin
      if (r.fixed) push_answer(r.st, r.cmd, r.len);
      else push_answer(st, cmd, len);
    end
    @(negedge clk_i);
  endtask

  // Result checker
  always @(posedge clk_i) begin : result_check
    answer_t got;
    answer_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {status_o, command_o, frame_length_o, reply_valid_o, reply_byte_o, end_of_run_o};
      if (answers_due.size() == 0) begin
        flag_error({"unexpected result ", show(got)});
      end else begin
        want = answers_due.pop_front();
        if (got !== want) flag_error({"result mismatch: expected ", show(want),
                                      " actual ", show(got)});
      end
    end
  end

  // Watchdog on handshake inactivity
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: changing stall styles, plus one long hold to back the block up
  initial begin : receiver
    int         cyc;
    int         style;
    logic [7:0] pat;
    bit         held;
    cyc         = 0;
    style       = 0;
    pat         = 8'hFF;
    held        = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && items_accepted >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      if (cyc % 40 == 0) begin
        style = $urandom_range(0, 3);
        pat   = 8'($urandom_range(1, 255));
      end
      case (style)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        2:       out_ready_i <= pat[cyc % 8];
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
      cyc++;
    end
  end

  // Stimulus
  initial begin : stimulus
    request_t   dir_rows[$];
    logic [7:0] fb[$];
    logic [7:0] csum;
    logic [7:0] b;
    logic [7:0] flip;
    logic       lst;
    bit         tmo;
    int         kind;
    int         flen;
    int         cut;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    mode_i       = xfc_pkg::MODE_DATA;
    byte_value_i = 8'h00;
    last_i       = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: mode, byte, last, then hand-written outcome where obvious
    // timeout straight after reset, byte and last ignored
    dir_rows.push_back(mk_req(xfc_pkg::MODE_TIMEOUT, 8'hFF, 1'b1, 1'b1, xfc_pkg::ST_RECV,
                              8'h00, 7'd0));
    // one-byte frame, too short
    dir_rows.push_back(mk_req(xfc_pkg::MODE_DATA, 8'h00, 1'b1, 1'b1, xfc_pkg::ST_RECV,
                              8'h00, 7'd1));
    // shortest good frame
    dir_rows.push_back(mk_req(xfc_pkg::MODE_DATA, 8'h59, 1'b0));
    dir_rows.push_back(mk_req(xfc_pkg::MODE_DATA, 8'h58, 1'b0));
    dir_rows.push_back(mk_req(xfc_pkg::MODE_DATA, 8'h00, 1'b0));
    dir_rows.push_back(mk_req(xfc_pkg::MODE_DATA, 8'hCC, 1'b0));
    dir_rows.push_back(mk_req(xfc_pkg::MODE_DATA, 8'h00, 1'b0));
    dir_rows.push_back(mk_req(xfc_pkg::MODE_DATA, 8'hFF, 1'b0));
    dir_rows.push_back(mk_req(xfc_pkg::MODE_DATA, 8'h00, 1'b0));
    dir_rows.push_back(mk_req(xfc_pkg::MODE_DATA, 8'h32, 1'b0));
    dir_rows.push_back(mk_req(xfc_pkg::MODE_DATA, 8'h0D, 1'b0));
    dir_rows.push_back(mk_req(xfc_pkg::MODE_DATA, 8'h0A, 1'b1, 1'b1, xfc_pkg::ST_OK,
                              8'hCC, 7'd10));
    // timeout before the command byte arrives
    dir_rows.push_back(mk_req(xfc_pkg::MODE_DATA, 8'hAA, 1'b0));
    dir_rows.push_back(mk_req(xfc_pkg::MODE_DATA, 8'h55, 1'b0));
    dir_rows.push_back(mk_req(xfc_pkg::MODE_DATA, 8'h12, 1'b0));
    dir_rows.push_back(mk_req(xfc_pkg::MODE_TIMEOUT, 8'h00, 1'b0, 1'b1, xfc_pkg::ST_RECV,
                              8'h00, 7'd3));
    // well-framed but wrong checksum
    dir_rows.push_back(mk_req(xfc_pkg::MODE_DATA, 8'h59, 1'b0));
    dir_rows.push_back(mk_req(xfc_pkg::MODE_DATA, 8'h58, 1'b0));
    dir_rows.push_back(mk_req(xfc_pkg::MODE_DATA, 8'hFF, 1'b0));
    dir_rows.push_back(mk_req(xfc_pkg::MODE_DATA, 8'h01, 1'b0));
    dir_rows.push_back(mk_req(xfc_pkg::MODE_DATA, 8'h00, 1'b0));
    dir_rows.push_back(mk_req(xfc_pkg::MODE_DATA, 8'h00, 1'b0));
    dir_rows.push_back(mk_req(xfc_pkg::MODE_DATA, 8'h00, 1'b0));
    dir_rows.push_back(mk_req(xfc_pkg::MODE_DATA, 8'h00, 1'b0));
    dir_rows.push_back(mk_req(xfc_pkg::MODE_DATA, 8'h0D, 1'b0));
    dir_rows.push_back(mk_req(xfc_pkg::MODE_DATA, 8'h0A, 1'b1, 1'b1, xfc_pkg::ST_SUM,
                              8'h01, 7'd10));
    foreach (dir_rows[k]) send_item(dir_rows[k]);

    // Random frames: nearly half well-formed, the rest corrupted, cut short, timed out or noise
    items_used = 0;
    while (items_used < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      flen = ($urandom_range(0, 9) == 0) ? $urandom_range(58, 72)
                                         : $urandom_range(xfc_pkg::MIN_LEN, 24);
      fb.delete();
      fb.push_back(xfc_pkg::HDR_0);
      fb.push_back(xfc_pkg::HDR_1);
      csum = xfc_pkg::HDR_0 ^ xfc_pkg::HDR_1;
      for (int i = 2; i < flen - 3; i++) begin
        b = 8'($urandom_range(0, 255));
        fb.push_back(b);
        csum = csum ^ b;
      end
      fb.push_back(csum);
      fb.push_back(xfc_pkg::TAIL_0);
      fb.push_back(xfc_pkg::TAIL_1);
      flip = 8'($urandom_range(1, 255));
      cut  = flen;
      tmo  = 1'b0;
      if (kind >= 45 && kind < 55) begin
        cut = $urandom_range(0, 1);
        fb[cut] = fb[cut] ^ flip;
        cut = flen;
      end else if (kind >= 55 && kind < 63) begin
        cut = flen - 1 - $urandom_range(0, 1);
        fb[cut] = fb[cut] ^ flip;
        cut = flen;
      end else if (kind >= 63 && kind < 71) begin
        fb[flen - 3] = fb[flen - 3] ^ flip;
      end else if (kind >= 71 && kind < 78) begin
        cut = $urandom_range(1, xfc_pkg::MIN_LEN - 1);
      end else if (kind >= 78 && kind < 86) begin
        cut = $urandom_range(0, flen - 1);
        tmo = 1'b1;
      end else if (kind >= 86) begin
        // noise never runs past the frame built above
        cut = $urandom_range(1, xfc_pkg::MIN_LEN);
        for (int i = 0; i < cut; i++) fb[i] = 8'($urandom_range(0, 255));
        tmo = ($urandom_range(0, 2) == 0);
      end
      for (int i = 0; i < cut; i++) begin
        if (kind >= 86) lst = ($urandom_range(0, 5) == 0);
        else lst = !tmo && (i == cut - 1);
        send_item(mk_req(xfc_pkg::MODE_DATA, fb[i], lst));
      end
      if (tmo) send_item(mk_req(xfc_pkg::MODE_TIMEOUT, 8'($urandom_range(0, 255)),
                                1'($urandom_range(0, 1))));
    end
    in_valid_i <= 1'b0;

    // Drain, then let the pipeline settle
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

### sim.f
rtl/xfc_pkg.sv
rtl/xfc_front.sv
rtl/xfc_queue.sv
rtl/xfc_back.sv
rtl/xor_frame_checker_with_nak_unit.sv
verif/tb_top.sv
